### rtl/core/sfum_pkg.sv
// shared types, constants and helpers for the stream find-until matcher
package sfum_pkg;

  localparam int MAX_PATTERN = 16;
  localparam int PIDX_W      = $clog2(MAX_PATTERN);
  localparam int PROG_W      = $clog2(MAX_PATTERN + 1);
  localparam int LEN_W       = 5;
  localparam int CFG_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] KIND_START   = 2'd0;
  localparam logic [1:0] KIND_DATA    = 2'd1;
  localparam logic [1:0] KIND_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    OUTCOME_FOUND   = 2'd0,
    OUTCOME_STOPPED = 2'd1,
    OUTCOME_TIMEOUT = 2'd2
  } outcome_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TARGET_LOW  = 3'd0,
    CFG_TARGET_HIGH = 3'd1,
    CFG_TARGET_LEN  = 3'd2,
    CFG_STOP_LOW    = 3'd3,
    CFG_STOP_HIGH   = 3'd4,
    CFG_STOP_LEN    = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    OP_START   = 2'd0,
    OP_DATA    = 2'd1,
    OP_TIMEOUT = 2'd2
  } op_t;

  typedef logic [MAX_PATTERN-1:0][7:0] pat_t;

  typedef struct packed {
    op_t        op;
    logic [7:0] data_byte;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qslot_t;

  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] len);
    eff_len = (len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : len;
  endfunction

  function automatic logic [7:0] pat_byte(input pat_t pat, input logic [PROG_W-1:0] idx);
    pat_byte = (idx < PROG_W'(MAX_PATTERN)) ? pat[idx[PIDX_W-1:0]] : 8'd0;
  endfunction

endpackage

### rtl/core/sfum_ifs.sv
// request and result channel interfaces
interface sfum_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] data_byte;

  modport source (output valid, output kind, output data_byte, input ready);
  modport sink (input valid, input kind, input data_byte, output ready);
endinterface

interface sfum_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] outcome;

  modport source (output valid, output outcome, input ready);
  modport sink (input valid, input outcome, output ready);
endinterface

### rtl/core/stream_find_until_matcher.sv
// top level of the stream find-until matcher
// a request is written into the command queue; its result, if any, is registered when the back end pops it
// throughput: one request per cycle while the command queue is not full, bounded by the index update
// a four-entry command queue lets requests be taken while a result is stalled
// reset clears all configuration registers, the search state and the queue
module stream_find_until_matcher (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sfum_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfum_pkg::CFG_W-1:0]     cfg_data,
  sfum_req_if.sink                       req,
  sfum_rsp_if.source                     rsp
);

  sfum_pkg::qslot_t push;
  sfum_pkg::qslot_t head;
  logic             full;
  logic             pop;

  sfum_front u_front (
    .req  (req),
    .full (full),
    .push (push)
  );

  sfum_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .push (push),
    .full (full),
    .head (head),
    .pop  (pop)
  );

  sfum_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .head      (head),
    .pop       (pop),
    .rsp       (rsp)
  );

endmodule

### rtl/core/sfum_front.sv
// front end: accepts requests and turns them into queue commands
module sfum_front (
  sfum_req_if.sink         req,
  input  logic             full,
  output sfum_pkg::qslot_t push
);

  logic known;

  always_comb begin
    known = 1'b1;
    push.cmd.op = sfum_pkg::OP_START;
    push.cmd.data_byte = req.data_byte;
    unique case (req.kind)
      sfum_pkg::KIND_START:   push.cmd.op = sfum_pkg::OP_START;
      sfum_pkg::KIND_DATA:    push.cmd.op = sfum_pkg::OP_DATA;
      sfum_pkg::KIND_TIMEOUT: push.cmd.op = sfum_pkg::OP_TIMEOUT;
      default:                known = 1'b0;
    endcase
    push.valid = req.valid && !full && known;
  end

  // undefined kinds are taken and dropped
  assign req.ready  = !full;

endmodule

### rtl/core/sfum_queue.sv
// command queue between front end and matcher
module sfum_queue (
  input  logic             clk,
  input  logic             rst,
  input  sfum_pkg::qslot_t push,
  output logic             full,
  output sfum_pkg::qslot_t head,
  input  logic             pop
);

  sfum_pkg::cmd_t                  slots [sfum_pkg::QUEUE_DEPTH];
  logic [sfum_pkg::QPTR_W-1:0]     wr_ptr;
  logic [sfum_pkg::QPTR_W-1:0]     rd_ptr;
  logic [sfum_pkg::QCNT_W-1:0]     count;
  logic                            do_push;
  logic                            do_pop;

  assign full       = (count == sfum_pkg::QCNT_W'(sfum_pkg::QUEUE_DEPTH));
  assign head.valid = (count != '0);
  assign head.cmd   = slots[rd_ptr];
  assign do_push    = push.valid && !full;
  assign do_pop     = pop && head.valid;

  function automatic logic [sfum_pkg::QPTR_W-1:0] bump(input logic [sfum_pkg::QPTR_W-1:0] p);
    bump = (p == sfum_pkg::QPTR_W'(sfum_pkg::QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push.cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

### rtl/core/sfum_back.sv
// back end: configuration registers, match indexes and result register
module sfum_back (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_write,
  input  logic [sfum_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sfum_pkg::CFG_W-1:0]       cfg_data,
  input  sfum_pkg::qslot_t                 head,
  output logic                             pop,
  sfum_rsp_if.source                       rsp
);

  logic [sfum_pkg::CFG_W-1:0]  target_low;
  logic [sfum_pkg::CFG_W-1:0]  target_high;
  logic [sfum_pkg::LEN_W-1:0]  target_length;
  logic [sfum_pkg::CFG_W-1:0]  stop_low;
  logic [sfum_pkg::CFG_W-1:0]  stop_high;
  logic [sfum_pkg::LEN_W-1:0]  stop_length;

  logic                        search_active;
  logic [sfum_pkg::PROG_W-1:0] target_progress;
  logic [sfum_pkg::PROG_W-1:0] stop_progress;
  logic                        out_valid;
  sfum_pkg::outcome_t          out_outcome;

  logic                        search_active_next;
  logic [sfum_pkg::PROG_W-1:0] target_progress_next;
  logic [sfum_pkg::PROG_W-1:0] stop_progress_next;
  logic                        res_valid;
  sfum_pkg::outcome_t          res_outcome;

  logic [sfum_pkg::LEN_W-1:0]  tlen;
  logic [sfum_pkg::LEN_W-1:0]  slen;
  sfum_pkg::pat_t              tpat;
  sfum_pkg::pat_t              spat;
  logic [sfum_pkg::PROG_W:0]   t_inc;
  logic [sfum_pkg::PROG_W:0]   s_inc;
  logic                        t_hit;
  logic                        s_hit;
  logic                        t_done;
  logic                        s_done;
  logic [sfum_pkg::PROG_W-1:0] t_step;
  logic [sfum_pkg::PROG_W-1:0] s_step;
  logic [7:0]                  b;

  assign pop = head.valid && (!out_valid || rsp.ready);

  always_comb begin
    b     = head.cmd.data_byte;
    tlen  = sfum_pkg::eff_len(target_length);
    slen  = sfum_pkg::eff_len(stop_length);
    tpat  = {target_high, target_low};
    spat  = {stop_high, stop_low};
    t_inc = {1'b0, target_progress} + (sfum_pkg::PROG_W + 1)'(1);
    s_inc = {1'b0, stop_progress} + (sfum_pkg::PROG_W + 1)'(1);
    t_hit = (b == sfum_pkg::pat_byte(tpat, target_progress));
    s_hit = (b == sfum_pkg::pat_byte(spat, stop_progress));
    t_done = t_hit && (t_inc >= (sfum_pkg::PROG_W + 1)'(tlen));
    s_done = s_hit && (s_inc >= (sfum_pkg::PROG_W + 1)'(slen));
    // simple restart: one if the byte opens the pattern
    if (t_hit) begin
      t_step = t_inc[sfum_pkg::PROG_W-1:0];
    end else begin
      t_step = (b == sfum_pkg::pat_byte(tpat, '0)) ? sfum_pkg::PROG_W'(1) : '0;
    end
    if (s_hit) begin
      s_step = s_inc[sfum_pkg::PROG_W-1:0];
    end else begin
      s_step = (b == sfum_pkg::pat_byte(spat, '0)) ? sfum_pkg::PROG_W'(1) : '0;
    end

    search_active_next   = search_active;
    target_progress_next = target_progress;
    stop_progress_next   = stop_progress;
    res_valid            = 1'b0;
    res_outcome          = sfum_pkg::OUTCOME_FOUND;

    unique case (head.cmd.op)
      sfum_pkg::OP_START: begin
        target_progress_next = '0;
        stop_progress_next   = '0;
        if (tlen == '0) begin
          search_active_next = 1'b0;
          res_valid          = 1'b1;
        end else begin
          search_active_next = 1'b1;
        end
      end
      sfum_pkg::OP_TIMEOUT: begin
        if (search_active) begin
          search_active_next = 1'b0;
          res_valid          = 1'b1;
          res_outcome        = sfum_pkg::OUTCOME_TIMEOUT;
        end
      end
      sfum_pkg::OP_DATA: begin
        if (search_active) begin
          if (tlen == '0) begin
            search_active_next = 1'b0;
            res_valid          = 1'b1;
          end else begin
            target_progress_next = t_step;
            if (t_done) begin
              search_active_next = 1'b0;
              res_valid          = 1'b1;
            end else if (slen != '0) begin
              stop_progress_next = s_step;
              if (s_done) begin
                search_active_next = 1'b0;
                res_valid          = 1'b1;
                res_outcome        = sfum_pkg::OUTCOME_STOPPED;
              end
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      target_low      <= '0;
      target_high     <= '0;
      target_length   <= '0;
      stop_low        <= '0;
      stop_high       <= '0;
      stop_length     <= '0;
      search_active   <= 1'b0;
      target_progress <= '0;
      stop_progress   <= '0;
      out_valid       <= 1'b0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          sfum_pkg::CFG_TARGET_LOW:  target_low    <= cfg_data;
          sfum_pkg::CFG_TARGET_HIGH: target_high   <= cfg_data;
          sfum_pkg::CFG_TARGET_LEN:  target_length <= cfg_data[sfum_pkg::LEN_W-1:0];
          sfum_pkg::CFG_STOP_LOW:    stop_low      <= cfg_data;
          sfum_pkg::CFG_STOP_HIGH:   stop_high     <= cfg_data;
          sfum_pkg::CFG_STOP_LEN:    stop_length   <= cfg_data[sfum_pkg::LEN_W-1:0];
          default: ;
        endcase
      end
      if (pop) begin
        search_active   <= search_active_next;
        target_progress <= target_progress_next;
        stop_progress   <= stop_progress_next;
        out_valid       <= res_valid;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && res_valid) begin
      out_outcome <= res_outcome;
    end
  end

  assign rsp.valid   = out_valid;
  assign rsp.outcome = out_outcome;

  a_tprog_range: assert property (@(posedge clk) disable iff (rst)
    target_progress <= sfum_pkg::PROG_W'(sfum_pkg::MAX_PATTERN))
    else $error("target index out of range");
  a_sprog_range: assert property (@(posedge clk) disable iff (rst)
    stop_progress <= sfum_pkg::PROG_W'(sfum_pkg::MAX_PATTERN))
    else $error("stop index out of range");
  a_result_from_pop: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(pop)) else $error("result without a command");
  a_outcome_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_outcome == sfum_pkg::OUTCOME_FOUND ||
                   out_outcome == sfum_pkg::OUTCOME_STOPPED ||
                   out_outcome == sfum_pkg::OUTCOME_TIMEOUT)) else $error("bad outcome");

endmodule

### tb/sv/sfum_checker.sv
// request/result monitor, search predictor and outcome comparison
`timescale 1ns / 1ps

module sfum_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [sfum_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sfum_pkg::CFG_W-1:0]     cfg_data,
  sfum_req_if                            req,
  sfum_rsp_if                            rsp,
  output int                             fail_count,
  output int                             pending
);

  logic [127:0]       target_pat;
  logic [127:0]       stop_pat;
  logic [4:0]         target_len_q;
  logic [4:0]         stop_len_q;
  logic               searching;
  logic [4:0]         target_pos;
  logic [4:0]         stop_pos;
  sfum_pkg::outcome_t expected_outcomes[$];
  int                 mismatches = 0;
  int                 waiting = 0;

  assign fail_count = mismatches;
  assign pending    = waiting;

  task automatic report_mismatch(input string what);
    $display("%0t ns mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic logic [4:0] clamp_len(input logic [4:0] len);
    return (len > 5'd16) ? 5'd16 : len;
  endfunction

  function automatic logic [7:0] pattern_at(input logic [127:0] pat, input logic [4:0] pos);
    return (pos < 5'd16) ? pat[{pos[3:0], 3'b000} +: 8] : 8'h00;
  endfunction

  // returns 1 when the pattern completes on this byte
  function automatic logic step_index(input logic [127:0] pat, input logic [4:0] len,
                                      input logic [7:0] b, input logic [4:0] pos_in,
                                      output logic [4:0] pos_out);
    if (b == pattern_at(pat, pos_in)) begin
      pos_out = pos_in + 5'd1;
      return pos_out >= len;
    end
    pos_out = (b == pat[7:0]) ? 5'd1 : 5'd0;
    return 1'b0;
  endfunction

  task automatic predict_request(input logic [1:0] kind, input logic [7:0] b);
    logic [4:0] tlen;
    logic [4:0] slen;
    logic [4:0] next_pos;
    logic       done;
    tlen = clamp_len(target_len_q);
    slen = clamp_len(stop_len_q);
    case (kind)
      sfum_pkg::KIND_START: begin
        target_pos = 5'd0;
        stop_pos   = 5'd0;
        if (tlen == 5'd0) begin
          searching = 1'b0;
          expected_outcomes.push_back(sfum_pkg::OUTCOME_FOUND);
        end else begin
          searching = 1'b1;
        end
      end
      sfum_pkg::KIND_TIMEOUT: begin
        if (searching) begin
          searching = 1'b0;
          expected_outcomes.push_back(sfum_pkg::OUTCOME_TIMEOUT);
        end
      end
      sfum_pkg::KIND_DATA: begin
        if (searching) begin
          done = (tlen == 5'd0);
          if (!done) begin
            done = step_index(target_pat, tlen, b, target_pos, next_pos);
            target_pos = next_pos;
          end
          if (done) begin
            searching = 1'b0;
            expected_outcomes.push_back(sfum_pkg::OUTCOME_FOUND);
          end else if (slen != 5'd0) begin
            done = step_index(stop_pat, slen, b, stop_pos, next_pos);
            stop_pos = next_pos;
            if (done) begin
              searching = 1'b0;
              expected_outcomes.push_back(sfum_pkg::OUTCOME_STOPPED);
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  always @(posedge clk) begin
    sfum_pkg::outcome_t want;
    if (rst) begin
      target_pat   = '0;
      stop_pat     = '0;
      target_len_q = '0;
      stop_len_q   = '0;
      searching    = 1'b0;
      target_pos   = '0;
      stop_pos     = '0;
      expected_outcomes.delete();
    end else begin
      if (rsp.valid && rsp.ready) begin
        if (expected_outcomes.size() == 0) begin
          report_mismatch($sformatf("unexpected result, outcome %0d", rsp.outcome));
        end else begin
          want = expected_outcomes.pop_front();
          if (rsp.outcome !== want) begin
            report_mismatch($sformatf("outcome %0d, expected %s", rsp.outcome, want.name()));
          end
        end
      end
      if (cfg_write) begin
        case (cfg_index)
          sfum_pkg::CFG_TARGET_LOW:  target_pat[63:0]   = cfg_data;
          sfum_pkg::CFG_TARGET_HIGH: target_pat[127:64] = cfg_data;
          sfum_pkg::CFG_TARGET_LEN:  target_len_q       = cfg_data[4:0];
          sfum_pkg::CFG_STOP_LOW:    stop_pat[63:0]     = cfg_data;
          sfum_pkg::CFG_STOP_HIGH:   stop_pat[127:64]   = cfg_data;
          sfum_pkg::CFG_STOP_LEN:    stop_len_q         = cfg_data[4:0];
          default: ;
        endcase
      end
      if (req.valid && req.ready) begin
        predict_request(req.kind, req.data_byte);
      end
    end
    waiting = expected_outcomes.size();
  end

endmodule

### tb/sv/tb_top.sv
// stimulus, handshake pacing, watchdog and verdict for the stream find-until matcher
`timescale 1ns / 1ps

module tb_top;

  localparam logic [1:0] KIND_UNUSED = 2'd3;
  localparam int HOLD_CYCLES = 80;
  localparam int IDLE_LIMIT  = 2000;
  localparam int RANDOM_ITEMS = 500;
  localparam int PHASE_ITEMS  = 60;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [sfum_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [sfum_pkg::CFG_W-1:0] cfg_data = '0;

  sfum_req_if req_ch ();
  sfum_rsp_if rsp_ch ();

  int fail_count;
  int pending;
  int sent_count = 0;
  int idle_count = 0;
  bit send_steady = 1'b0;
  bit rsp_steady = 1'b0;
  bit hold_rsp = 1'b0;

  logic [15:0][7:0] tgt_bytes;
  logic [15:0][7:0] stp_bytes;
  logic [4:0] tgt_len;
  logic [4:0] stp_len;
  logic [7:0] alphabet[3];

  stream_find_until_matcher dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .rsp       (rsp_ch)
  );

  sfum_checker checker_i (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .req        (req_ch),
    .rsp        (rsp_ch),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_count <= 0;
    end else begin
      idle_count <= idle_count + 1;
      if (idle_count >= IDLE_LIMIT) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  function automatic int idle_len();
    return ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
  endfunction

  function automatic logic [4:0] pick_len();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return 5'd0;
    if (r == 1) return 5'd1;
    if (r < 4) return 5'd16;
    if (r == 4) return 5'($urandom_range(17, 31));
    return 5'($urandom_range(2, 8));
  endfunction

  function automatic int eff_count(input logic [4:0] len);
    return (len > 5'd16) ? 16 : int'(len);
  endfunction

  function automatic logic [7:0] alpha_byte();
    return alphabet[$urandom_range(0, 2)];
  endfunction

  // result side: random stalls, plus one long hold-off on request
  initial begin
    int n;
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_rsp) begin
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_rsp = 1'b0;
        rsp_ch.ready <= 1'b1;
      end else if (!rst && !rsp_steady && $urandom_range(0, 3) == 0) begin
        n = idle_len();
        rsp_ch.ready <= 1'b0;
        repeat (n) @(negedge clk);
        rsp_ch.ready <= 1'b1;
      end else begin
        rsp_ch.ready <= !rst;
      end
    end
  end

  task automatic send_req(input logic [1:0] kind, input logic [7:0] value);
    int gap;
    gap = (!send_steady && $urandom_range(0, 3) == 0) ? idle_len() : 0;
    @(negedge clk);
    if (gap > 0) begin
      req_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid     <= 1'b1;
    req_ch.kind      <= kind;
    req_ch.data_byte <= value;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    if (kind != KIND_UNUSED) sent_count++;
  endtask

  task automatic write_reg(input sfum_pkg::cfg_reg_t idx, input logic [63:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic drain();
    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (12) @(negedge clk);
  endtask

  task automatic load_patterns();
    write_reg(sfum_pkg::CFG_TARGET_LOW, tgt_bytes[7:0]);
    write_reg(sfum_pkg::CFG_TARGET_HIGH, tgt_bytes[15:8]);
    write_reg(sfum_pkg::CFG_TARGET_LEN, 64'(tgt_len));
    write_reg(sfum_pkg::CFG_STOP_LOW, stp_bytes[7:0]);
    write_reg(sfum_pkg::CFG_STOP_HIGH, stp_bytes[15:8]);
    write_reg(sfum_pkg::CFG_STOP_LEN, 64'(stp_len));
  endtask

  task automatic send_pattern(input bit of_target, input bit whole);
    int len;
    int n;
    len = eff_count(of_target ? tgt_len : stp_len);
    if (len == 0) begin
      send_req(sfum_pkg::KIND_DATA, alpha_byte());
    end else begin
      n = whole ? len : $urandom_range(1, len);
      for (int i = 0; i < n; i++) begin
        send_req(sfum_pkg::KIND_DATA, of_target ? tgt_bytes[i] : stp_bytes[i]);
      end
    end
  endtask

  task automatic run_sequence();
    int chunks;
    int c;
    if ($urandom_range(0, 99) < 8) begin
      send_req(2'($urandom_range(0, 3)), 8'($urandom));
    end else begin
      send_req(sfum_pkg::KIND_START, 8'($urandom));
      chunks = $urandom_range(1, 4);
      for (int k = 0; k < chunks; k++) begin
        c = $urandom_range(0, 9);
        if (c < 4) begin
          send_pattern(1'b1, c < 2);
        end else if (c < 6) begin
          send_pattern(1'b0, c == 4);
        end else if (c < 9) begin
          repeat ($urandom_range(1, 4)) send_req(sfum_pkg::KIND_DATA, alpha_byte());
        end else begin
          send_req(sfum_pkg::KIND_DATA, 8'($urandom));
        end
        if ($urandom_range(0, 19) == 0) send_req(sfum_pkg::KIND_START, 8'($urandom));
        if ($urandom_range(0, 19) == 0) send_req(KIND_UNUSED, 8'($urandom));
      end
      if ($urandom_range(0, 9) == 0) send_req(sfum_pkg::KIND_TIMEOUT, 8'($urandom));
    end
  endtask

  task automatic pick_phase(input int phase);
    bit from_alpha;
    for (int i = 0; i < 3; i++) alphabet[i] = 8'($urandom);
    from_alpha = ($urandom_range(0, 4) != 0);
    for (int i = 0; i < 16; i++) begin
      tgt_bytes[i] = from_alpha ? alpha_byte() : 8'($urandom);
      stp_bytes[i] = from_alpha ? alpha_byte() : 8'($urandom);
    end
    tgt_len = pick_len();
    stp_len = ($urandom_range(0, 3) == 0) ? 5'd0 : pick_len();
    case (phase)
      0: begin
        alphabet  = '{8'hFF, 8'h00, 8'hFF};
        tgt_bytes = '1;
        tgt_len   = 5'd31;
        stp_bytes = '0;
        stp_len   = 5'd16;
      end
      1: begin
        alphabet  = '{8'h00, 8'hFF, 8'h00};
        tgt_bytes = '0;
        tgt_len   = 5'd16;
        stp_bytes = '1;
        stp_len   = 5'd31;
      end
      default: ;
    endcase
  endtask

  initial begin
    int goal;
    int phase;
    int phase_base;
    req_ch.valid     = 1'b0;
    req_ch.kind      = sfum_pkg::KIND_START;
    req_ch.data_byte = 8'h00;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // registers still at reset: empty target, no terminator
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h55);
    send_req(sfum_pkg::KIND_TIMEOUT, 8'h00);
    send_req(KIND_UNUSED, 8'hAA);
    drain();

    tgt_bytes = '0;
    tgt_bytes[2:0] = {8'h63, 8'h62, 8'h61};
    tgt_len = 5'd3;
    stp_bytes = '0;
    stp_bytes[1:0] = {8'h0A, 8'h0D};
    stp_len = 5'd2;
    load_patterns();

    // restart on first byte after a mismatch
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h61);
    send_req(sfum_pkg::KIND_DATA, 8'h61);
    send_req(sfum_pkg::KIND_DATA, 8'h62);
    send_req(sfum_pkg::KIND_DATA, 8'h63);
    // terminator first
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h78);
    send_req(sfum_pkg::KIND_DATA, 8'h0D);
    send_req(sfum_pkg::KIND_DATA, 8'h0A);
    // timeout with an ignored kind in between
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h61);
    send_req(KIND_UNUSED, 8'h63);
    send_req(sfum_pkg::KIND_TIMEOUT, 8'h00);
    // restart drops the running search
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h61);
    send_req(sfum_pkg::KIND_START, 8'h00);
    send_req(sfum_pkg::KIND_DATA, 8'h62);
    send_req(sfum_pkg::KIND_DATA, 8'h63);
    // shorten the target mid search, then empty it mid search
    send_req(sfum_pkg::KIND_DATA, 8'h61);
    send_req(sfum_pkg::KIND_DATA, 8'h62);
    drain();
    write_reg(sfum_pkg::CFG_TARGET_LEN, 64'd1);
    send_req(sfum_pkg::KIND_DATA, 8'h63);
    send_req(sfum_pkg::KIND_START, 8'h00);
    drain();
    write_reg(sfum_pkg::CFG_TARGET_LEN, 64'd0);
    send_req(sfum_pkg::KIND_DATA, 8'h00);
    drain();

    // back-pressure: empty target makes every start a result
    send_steady = 1'b1;
    hold_rsp = 1'b1;
    repeat (24) send_req(sfum_pkg::KIND_START, 8'($urandom));
    send_steady = 1'b0;

    goal = sent_count + RANDOM_ITEMS;
    phase = 0;
    while (sent_count < goal) begin
      drain();
      pick_phase(phase);
      load_patterns();
      send_steady = ($urandom_range(0, 4) == 0);
      rsp_steady  = ($urandom_range(0, 4) == 0);
      phase_base  = sent_count;
      while (sent_count - phase_base < PHASE_ITEMS) run_sequence();
      phase++;
    end

    @(negedge clk);
    req_ch.valid <= 1'b0;
    wait (pending == 0);
    repeat (20) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### sim.f
rtl/core/sfum_pkg.sv
rtl/core/sfum_ifs.sv
rtl/core/sfum_front.sv
rtl/core/sfum_queue.sv
rtl/core/sfum_back.sv
rtl/core/stream_find_until_matcher.sv
tb/sv/sfum_checker.sv
tb/sv/tb_top.sv
